[hdl/assert_macros.svh]
// Assertion shorthands for the files that check their own logic.
// Each expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bdt_pkg.sv]
package bdt_pkg;

  localparam int ACC_W = 40;
  localparam int GAP_W = 17;
  localparam int OFF_W = 16;
  localparam int REF_W = 16;

  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_TERM  = 1'b1;

  localparam logic [1:0] DIR_LESS    = 2'd0;
  localparam logic [1:0] DIR_EQUAL   = 2'd1;
  localparam logic [1:0] DIR_GREATER = 2'd2;
  localparam logic [1:0] DIR_ANY     = 2'd3;

  localparam logic [1:0] RSN_HELD     = 2'd0;
  localparam logic [1:0] RSN_VIOLATED = 2'd1;
  localparam logic [1:0] RSN_MISMATCH = 2'd2;
  localparam logic [1:0] RSN_COUNTS   = 2'd3;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic                    is_term;
    logic                    last_t;
    logic                    last_sub;
    logic                    counts;
    logic                    mismatch;
    logic signed [GAP_W-1:0] gap;
  } bdt_ctrl_t;

  // Back end status seen by the top level.
  typedef struct packed {
    logic emit;
    logic decided;
    logic counts;
  } bdt_stat_t;

  // Saturates a value two bits wider than the accumulator to its range.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
    if (v[ACC_W+1:ACC_W-1] == 3'b000 || v[ACC_W+1:ACC_W-1] == 3'b111) begin
      return v[ACC_W-1:0];
    end
    return v[ACC_W+1] ? ACC_MIN : ACC_MAX;
  endfunction

endpackage

[hdl/bdt_if.sv]
interface bdt_in_if #(
  parameter int COEFF_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
);
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [bdt_pkg::OFF_W-1:0]    first_offset;
  logic signed [bdt_pkg::OFF_W-1:0]    second_offset;
  logic        [bdt_pkg::REF_W-1:0]    first_index_ref;
  logic        [bdt_pkg::REF_W-1:0]    second_index_ref;
  logic                                counts_differ;
  logic signed [COEFF_WIDTH-1:0]       first_coeff;
  logic signed [COEFF_WIDTH-1:0]       second_coeff;
  logic        [COUNT_WIDTH-1:0]       trip_count;
  logic        [1:0]                   direction;
  logic                                last_term;
  logic                                last_subscript;

  modport source (
    output valid, action, first_offset, second_offset, first_index_ref,
           second_index_ref, counts_differ, first_coeff, second_coeff,
           trip_count, direction, last_term, last_subscript,
    input  ready
  );
  modport sink (
    input  valid, action, first_offset, second_offset, first_index_ref,
           second_index_ref, counts_differ, first_coeff, second_coeff,
           trip_count, direction, last_term, last_subscript,
    output ready
  );
endinterface

interface bdt_out_if;
  logic       valid;
  logic       ready;
  logic       dependent;
  logic [1:0] reason;

  modport source (output valid, dependent, reason, input ready);
  modport sink (input valid, dependent, reason, output ready);
endinterface

[hdl/bdt_front.sv]
module bdt_front #(
  parameter int COEFF_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  bdt_in_if.sink                        in_ch,
  input  logic                          q_full,
  output logic                          push,
  output bdt_pkg::bdt_ctrl_t            ctrl,
  output logic        [COEFF_WIDTH:0]   m_lo,
  output logic        [COEFF_WIDTH:0]   m_hi,
  output logic signed [COUNT_WIDTH:0]   t,
  output logic signed [COEFF_WIDTH+2:0] c_lo,
  output logic signed [COEFF_WIDTH+2:0] c_hi
);
  import bdt_pkg::*;

  localparam int XW = COEFF_WIDTH + 3;

  function automatic logic signed [XW-1:0] pos_x(input logic signed [XW-1:0] v);
    return (v > 0) ? v : '0;
  endfunction

  function automatic logic signed [XW-1:0] neg_x(input logic signed [XW-1:0] v);
    return (v < 0) ? -v : '0;
  endfunction

  logic signed [XW-1:0]          a, b, pa, na, pb, nb, d, e, mlx, mhx, clx, chx;
  logic signed [COUNT_WIDTH:0]   u_x;
  logic                          is_term;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign is_term     = (in_ch.action == ACT_TERM);

  always_comb begin
    ctrl.is_term  = is_term;
    ctrl.last_t   = is_term && (in_ch.last_term || in_ch.last_subscript);
    ctrl.last_sub = is_term && in_ch.last_subscript;
    ctrl.counts   = in_ch.counts_differ;
    ctrl.mismatch = (in_ch.first_index_ref != in_ch.second_index_ref);
    ctrl.gap      = GAP_W'(in_ch.second_offset) - GAP_W'(in_ch.first_offset);
  end

  // Each direction becomes one product magnitude per bound, a shared
  // multiplier (U or U - 1) and a small additive correction per bound.
  always_comb begin
    a   = XW'(in_ch.first_coeff);
    b   = XW'(in_ch.second_coeff);
    pa  = pos_x(a);
    na  = neg_x(a);
    pb  = pos_x(b);
    nb  = neg_x(b);
    u_x = $signed({1'b0, in_ch.trip_count});
    d   = '0;
    e   = '0;
    case (in_ch.direction)
      DIR_LESS: begin
        d   = na + b;
        e   = pa - b;
        mlx = pos_x(d);
        clx = neg_x(d) + pa - b;
        mhx = pos_x(e);
        chx = -(neg_x(e) + na) - b;
        t   = u_x - (COUNT_WIDTH+1)'(1);
      end
      DIR_EQUAL: begin
        d   = a - b;
        mlx = neg_x(d);
        clx = pos_x(d);
        mhx = pos_x(d);
        chx = -neg_x(d);
        t   = u_x;
      end
      DIR_GREATER: begin
        d   = a - pb;
        e   = a - nb;
        mlx = neg_x(d);
        clx = pos_x(d) + nb + a;
        mhx = pos_x(e);
        chx = neg_x(e) + pb + a;
        t   = u_x - (COUNT_WIDTH+1)'(1);
      end
      default: begin
        mlx = na + pb;
        clx = pa + nb;
        mhx = pa + nb;
        chx = -(na + pb);
        t   = u_x;
      end
    endcase
    if (!is_term) begin
      mlx = '0;
      mhx = '0;
      clx = '0;
      chx = '0;
    end
    m_lo = mlx[COEFF_WIDTH:0];
    m_hi = mhx[COEFF_WIDTH:0];
    c_lo = clx;
    c_hi = chx;
  end

endmodule

[hdl/bdt_queue.sv]
module bdt_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bdt_pkg::bdt_ctrl_t push_ctrl,
  input  logic [DW-1:0]      push_data,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output bdt_pkg::bdt_ctrl_t ctrl,
  output logic [DW-1:0]      data
);
  import bdt_pkg::*;

  // DEPTH is a power of two so that the pointers wrap on their own.
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bdt_ctrl_t         ctrl_r [DEPTH];
  logic [DW-1:0]     data_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     cnt_r;
  logic              do_pop;

  assign full   = (cnt_r == CW'(DEPTH));
  assign valid  = (cnt_r != '0);
  assign do_pop = pop && valid;
  assign ctrl   = ctrl_r[rd_ptr_r];
  assign data   = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_r[wr_ptr_r] <= push_ctrl;
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/bdt_back.sv]
module bdt_back #(
  parameter int COEFF_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  bdt_pkg::bdt_ctrl_t            q_ctrl,
  input  logic        [COEFF_WIDTH:0]   q_m_lo,
  input  logic        [COEFF_WIDTH:0]   q_m_hi,
  input  logic signed [COUNT_WIDTH:0]   q_t,
  input  logic signed [COEFF_WIDTH+2:0] q_c_lo,
  input  logic signed [COEFF_WIDTH+2:0] q_c_hi,
  output logic                          q_pop,
  bdt_out_if.source                     out_ch,
  output bdt_pkg::bdt_stat_t            stat
);
  import bdt_pkg::*;

  localparam int PW = COEFF_WIDTH + COUNT_WIDTH + 3;
  localparam int EW = (PW > ACC_W + 2) ? PW : ACC_W + 2;

  function automatic logic signed [ACC_W-1:0] sat_prod(input logic signed [PW-1:0] p);
    logic signed [EW-1:0] x;
    x = EW'(p);
    if (x[EW-1:ACC_W-1] == '0 || x[EW-1:ACC_W-1] == '1) begin
      return x[ACC_W-1:0];
    end
    return x[EW-1] ? ACC_MIN : ACC_MAX;
  endfunction

  logic                          adv;
  // Stage 1: products.
  logic                          s1_v_r;
  bdt_ctrl_t                     s1_ctrl_r;
  logic signed [PW-1:0]          s1_plo_r, s1_phi_r;
  logic signed [COEFF_WIDTH+2:0] s1_clo_r, s1_chi_r;
  // Stage 2: saturated bounds of one term.
  logic                          s2_v_r;
  bdt_ctrl_t                     s2_ctrl_r;
  logic signed [ACC_W-1:0]       s2_lo_r, s2_hi_r;
  logic signed [ACC_W-1:0]       lo_term, hi_term;
  // Stage 3: test state and result register.
  logic signed [ACC_W-1:0]       lo_sum_r, hi_sum_r, lo_sum_nxt, hi_sum_nxt;
  logic signed [GAP_W-1:0]       gap_r, gap_nxt;
  logic signed [ACC_W-1:0]       gap_ext;
  logic                          decided_r, decided_nxt;
  logic [1:0]                    reason_r, reason_nxt;
  logic                          counts_r, counts_nxt;
  logic                          emit;
  logic                          out_valid_r;
  logic                          out_dep_r, out_dep_nxt;
  logic [1:0]                    out_rsn_r, out_rsn_nxt;

  assign adv   = !out_valid_r || out_ch.ready;
  assign q_pop = adv && q_valid;

  always_comb begin
    lo_term = sat_acc(-((ACC_W+2)'(sat_prod(s1_plo_r))) + (ACC_W+2)'(s1_clo_r));
    hi_term = sat_acc((ACC_W+2)'(sat_prod(s1_phi_r)) + (ACC_W+2)'(s1_chi_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= q_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctrl_r <= q_ctrl;
      s1_plo_r  <= PW'($signed({1'b0, q_m_lo})) * PW'(q_t);
      s1_phi_r  <= PW'($signed({1'b0, q_m_hi})) * PW'(q_t);
      s1_clo_r  <= q_c_lo;
      s1_chi_r  <= q_c_hi;
      s2_ctrl_r <= s1_ctrl_r;
      s2_lo_r   <= lo_term;
      s2_hi_r   <= hi_term;
    end
  end

  always_comb begin
    lo_sum_nxt  = lo_sum_r;
    hi_sum_nxt  = hi_sum_r;
    gap_nxt     = gap_r;
    decided_nxt = decided_r;
    reason_nxt  = reason_r;
    counts_nxt  = counts_r;
    emit        = 1'b0;
    gap_ext     = ACC_W'(gap_r);
    if (adv && s2_v_r) begin
      counts_nxt = counts_r || s2_ctrl_r.counts;
      if (!s2_ctrl_r.is_term) begin
        gap_nxt    = s2_ctrl_r.gap;
        lo_sum_nxt = '0;
        hi_sum_nxt = '0;
        if (!decided_r && s2_ctrl_r.mismatch) begin
          decided_nxt = 1'b1;
          reason_nxt  = RSN_MISMATCH;
        end
      end else begin
        lo_sum_nxt = sat_acc((ACC_W+2)'(lo_sum_r) + (ACC_W+2)'(s2_lo_r));
        hi_sum_nxt = sat_acc((ACC_W+2)'(hi_sum_r) + (ACC_W+2)'(s2_hi_r));
        if (s2_ctrl_r.last_t && !decided_r &&
            !(lo_sum_nxt <= gap_ext && gap_ext <= hi_sum_nxt)) begin
          decided_nxt = 1'b1;
          reason_nxt  = RSN_VIOLATED;
        end
        emit = s2_ctrl_r.last_sub;
      end
    end
    out_dep_nxt = !(!counts_nxt && decided_nxt && reason_nxt == RSN_VIOLATED);
    out_rsn_nxt = counts_nxt ? RSN_COUNTS : (decided_nxt ? reason_nxt : RSN_HELD);
    if (emit) begin
      lo_sum_nxt  = '0;
      hi_sum_nxt  = '0;
      gap_nxt     = '0;
      decided_nxt = 1'b0;
      reason_nxt  = RSN_HELD;
      counts_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_sum_r    <= '0;
      hi_sum_r    <= '0;
      gap_r       <= '0;
      decided_r   <= 1'b0;
      reason_r    <= RSN_HELD;
      counts_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lo_sum_r  <= lo_sum_nxt;
      hi_sum_r  <= hi_sum_nxt;
      gap_r     <= gap_nxt;
      decided_r <= decided_nxt;
      reason_r  <= reason_nxt;
      counts_r  <= counts_nxt;
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_dep_r <= out_dep_nxt;
      out_rsn_r <= out_rsn_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.dependent = out_dep_r;
  assign out_ch.reason    = out_rsn_r;

  assign stat.emit    = emit;
  assign stat.decided = decided_r;
  assign stat.counts  = counts_r;

endmodule

[hdl/banerjee_dependence_test_top.sv]
// Banerjee inequality test for two array references under one direction vector.
// Requests arrive on in_ch: a begin request per subscript pair (offsets, index
// identities), then one term request per loop level (coefficients, trip count,
// direction). On the term request flagged last_subscript one verdict leaves on
// out_ch as a single request carrying dependent and reason.
// Both channels use valid/ready; a request moves when both are high.
// Throughput is one request per cycle, sustained, while the receiver takes each
// verdict as it is presented. A closing term request passes through the queue,
// the product stage and the bound stage, after which the accumulate step and
// the verdict register load together; the accumulate step is the only loop
// and closes through its own registers.
// Reset (synchronous, rst_n low) empties the queue and the pipeline, clears the
// sums, the offset gap, the held decision and the subscript-count flag.
// If the receiver holds out_ch.ready low, the verdict stays in its output
// register, the back end pauses and the four-entry queue keeps taking
// requests until it fills; only then does in_ch.ready fall.
`include "assert_macros.svh"

module banerjee_dependence_test_top #(
  parameter int COEFF_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bdt_in_if.sink     in_ch,
  bdt_out_if.source  out_ch
);
  import bdt_pkg::*;

  // Operand bundle between the front and back ends: two product magnitudes,
  // the shared multiplier and two corrections.
  localparam int DW = 2 * (COEFF_WIDTH + 1) + (COUNT_WIDTH + 1) + 2 * (COEFF_WIDTH + 3);

  logic                          f_push;
  bdt_ctrl_t                     f_ctrl;
  logic        [COEFF_WIDTH:0]   f_m_lo, f_m_hi;
  logic signed [COUNT_WIDTH:0]   f_t;
  logic signed [COEFF_WIDTH+2:0] f_c_lo, f_c_hi;

  logic                          q_full, q_valid, q_pop;
  bdt_ctrl_t                     q_ctrl;
  logic [DW-1:0]                 q_data;
  logic        [COEFF_WIDTH:0]   q_m_lo, q_m_hi;
  logic signed [COUNT_WIDTH:0]   q_t;
  logic signed [COEFF_WIDTH+2:0] q_c_lo, q_c_hi;

  bdt_stat_t                     back_stat;

  // The front end classifies each request by its direction and forms the
  // operands of the two bounds; nothing in it waits on earlier requests.
  bdt_front #(
    .COEFF_WIDTH (COEFF_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (f_push),
    .ctrl   (f_ctrl),
    .m_lo   (f_m_lo),
    .m_hi   (f_m_hi),
    .t      (f_t),
    .c_lo   (f_c_lo),
    .c_hi   (f_c_hi)
  );

  // A short queue lets the front end keep taking requests while the result
  // side is stalled.
  bdt_queue #(
    .DW    (DW),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_ctrl (f_ctrl),
    .push_data ({f_m_lo, f_m_hi, f_t, f_c_lo, f_c_hi}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .ctrl      (q_ctrl),
    .data      (q_data)
  );

  assign {q_m_lo, q_m_hi, q_t, q_c_lo, q_c_hi} = q_data;

  // The back end multiplies, saturates and accumulates, keeps the decision
  // and drives the verdict register.
  bdt_back #(
    .COEFF_WIDTH (COEFF_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ctrl  (q_ctrl),
    .q_m_lo  (q_m_lo),
    .q_m_hi  (q_m_hi),
    .q_t     (q_t),
    .q_c_lo  (q_c_lo),
    .q_c_hi  (q_c_hi),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .stat    (back_stat)
  );

  // A verdict decided in the back end is presented in the following cycle.
  `ASSERT_NEXT(a_emit_shows, back_stat.emit, out_ch.valid, "verdict not presented")
  // Once a verdict has gone out the test state is back at its reset value.
  `ASSERT_NEXT(a_emit_clears, back_stat.emit, !back_stat.decided && !back_stat.counts, "state not cleared after verdict")
  // A new verdict only ever follows a closing term in the back end.
  `ASSERT_IMPL(a_out_origin, $rose(out_ch.valid), $past(back_stat.emit), "verdict without closing term")

endmodule

[bench/banerjee_dependence_test_top_tb.sv]
module banerjee_dependence_test_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdt_pkg::*;

  // The block is built at its default widths; the bench mirrors them.
  localparam int COEFF_W = 16;
  localparam int COUNT_W = 16;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 3;
  localparam int DIRECTED_N   = 20;
  localparam int RANDOM_ITEMS = 750;
  // A verdict leaves once its closing term has passed the queue and the back end; allow a margin on top.
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;
  // The receiver's long hold-off, long enough to fill the four-entry queue.
  localparam int HOLD_CYCLES  = 150;
  // Terms in one pair needed to drive a running sum into saturation.
  localparam int SAT_LEVELS   = 135;

  localparam longint LIM_HI = 64'sd549755813887;
  localparam longint LIM_LO = -64'sd549755813888;

  // One request as it is offered on the input channel.
  typedef struct packed {
    logic                      action;
    logic signed [OFF_W-1:0]   first_offset;
    logic signed [OFF_W-1:0]   second_offset;
    logic        [REF_W-1:0]   first_index_ref;
    logic        [REF_W-1:0]   second_index_ref;
    logic                      counts_differ;
    logic signed [COEFF_W-1:0] first_coeff;
    logic signed [COEFF_W-1:0] second_coeff;
    logic        [COUNT_W-1:0] trip_count;
    logic        [1:0]         direction;
    logic                      last_term;
    logic                      last_subscript;
  } bdt_request_t;

  typedef struct packed {
    logic       dependent;
    logic [1:0] reason;
  } verdict_t;

  // A directed row carries its verdict only where it is obvious by inspection.
  typedef struct packed {
    bdt_request_t req;
    logic         typed;
    logic         dependent;
    logic [1:0]   reason;
  } directed_row_t;

  typedef enum int {SHAPE_PLAIN, SHAPE_SAT_LOW, SHAPE_SAT_HIGH} test_shape_t;

  logic clk = 1'b0;
  logic rst_n;

  bdt_in_if #(.COEFF_WIDTH(COEFF_W), .COUNT_WIDTH(COUNT_W)) in_ch();
  bdt_out_if out_ch();

  banerjee_dependence_test_top #(
    .COEFF_WIDTH(COEFF_W),
    .COUNT_WIDTH(COUNT_W)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Directed stimulus. Columns of each request, left to right: action,
  // first and second offset, first and second index identity, counts_differ,
  // first and second coefficient, trip count, direction, last_term and
  // last_subscript. Then whether a verdict is typed in, and that verdict.
  directed_row_t directed_rows [DIRECTED_N] = '{
    // A lone term straight after reset, flagged last subscript without last term.
    '{'{ACT_TERM,  0, 0, 0, 0, 0, 0, 0, 0, DIR_EQUAL, 0, 1}, 1, 1, RSN_HELD},
    // Index identities differ on the begin request.
    '{'{ACT_BEGIN, 0, 0, 1, 2, 0, 0, 0, 0, DIR_EQUAL, 0, 0}, 0, 0, RSN_HELD},
    '{'{ACT_TERM,  0, 0, 0, 0, 0, 1, 1, 3, DIR_EQUAL, 1, 1}, 1, 1, RSN_MISMATCH},
    // Subscript counts differ, flagged on a term request.
    '{'{ACT_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, DIR_EQUAL, 0, 0}, 0, 0, RSN_HELD},
    '{'{ACT_TERM,  0, 0, 0, 0, 1, 0, 0, 1, DIR_ANY,   1, 1}, 1, 1, RSN_COUNTS},
    // A violated pair, then a mismatched one: the first decision must stand.
    '{'{ACT_BEGIN, 0, 100, 0, 0, 0, 0, 0, 0, DIR_EQUAL, 0, 0}, 0, 0, RSN_HELD},
    '{'{ACT_TERM,  0, 0, 0, 0, 0, 0, 0, 5, DIR_EQUAL, 1, 0}, 0, 0, RSN_HELD},
    '{'{ACT_BEGIN, 0, 0, 7, 9, 0, 0, 0, 0, DIR_EQUAL, 0, 0}, 0, 0, RSN_HELD},
    '{'{ACT_TERM,  0, 0, 0, 0, 0, 0, 0, 1, DIR_EQUAL, 0, 1}, 1, 0, RSN_VIOLATED},
    // Field extremes in every direction, zero trip counts among them. The begin
    // request carries both last flags, which must be ignored.
    '{'{ACT_BEGIN, 'h8000, 'h7fff, 'hffff, 'hffff, 0, 0, 0, 0, DIR_EQUAL, 1, 1},
      0, 0, RSN_HELD},
    '{'{ACT_TERM,  0, 0, 0, 0, 0, 'h8000, 'h7fff, 'hffff, DIR_LESS, 0, 0}, 0, 0, RSN_HELD},
    '{'{ACT_TERM,  0, 0, 0, 0, 0, 'h7fff, 'h8000, 0, DIR_GREATER, 0, 0}, 0, 0, RSN_HELD},
    '{'{ACT_TERM,  0, 0, 0, 0, 0, 'h8000, 'h8000, 0, DIR_LESS, 0, 0}, 0, 0, RSN_HELD},
    '{'{ACT_TERM,  0, 0, 0, 0, 0, 'h7fff, 'h7fff, 'hffff, DIR_ANY, 1, 0}, 0, 0, RSN_HELD},
    '{'{ACT_BEGIN, 'h7fff, 'h8000, 0, 0, 0, 0, 0, 0, DIR_EQUAL, 0, 0}, 0, 0, RSN_HELD},
    '{'{ACT_TERM,  0, 0, 0, 0, 0, 'h8000, 'h7fff, 'hffff, DIR_ANY, 0, 0}, 0, 0, RSN_HELD},
    '{'{ACT_TERM,  0, 0, 0, 0, 0, 3, -2, 0, DIR_EQUAL, 0, 0}, 0, 0, RSN_HELD},
    '{'{ACT_TERM,  0, 0, 0, 0, 0, -1, 1, 1, DIR_GREATER, 1, 1}, 0, 0, RSN_HELD},
    // Subscript counts differ, flagged on a begin request this time.
    '{'{ACT_BEGIN, 0, 0, 0, 0, 1, 0, 0, 0, DIR_EQUAL, 0, 0}, 0, 0, RSN_HELD},
    '{'{ACT_TERM,  0, 0, 0, 0, 0, 2, 3, 4, DIR_ANY, 1, 1}, 1, 1, RSN_COUNTS}
  };

  // Predictor state, kept at the widths of the block's own registers.
  logic signed [ACC_W-1:0] lower_bound_sum;
  logic signed [ACC_W-1:0] upper_bound_sum;
  logic signed [GAP_W-1:0] subscript_gap;
  logic                    decision_held;
  logic [1:0]              held_cause;
  logic                    count_mismatch_seen;

  verdict_t expected_verdicts [$];
  int       fault_count   = 0;
  int       verdicts_seen = 0;
  int       requests_sent = 0;
  int       tx_burst      = 0;

  function automatic void clear_predictor();
    lower_bound_sum     = '0;
    upper_bound_sum     = '0;
    subscript_gap       = '0;
    decision_held       = 1'b0;
    held_cause          = RSN_HELD;
    count_mismatch_seen = 1'b0;
  endfunction

  function automatic longint clip_acc(longint v);
    if (v > LIM_HI) return LIM_HI;
    if (v < LIM_LO) return LIM_LO;
    return v;
  endfunction

  function automatic longint plus_part(longint t);
    return (t > 0) ? t : 0;
  endfunction

  function automatic longint minus_part(longint t);
    return (t < 0) ? -t : 0;
  endfunction

  // Product saturated to the accumulator range; the magnitude test comes
  // first so that nothing overflows 64 bits.
  function automatic longint sat_product(longint x, longint y);
    longint ax;
    longint ay;
    bit     flip;
    ax   = (x < 0) ? -x : x;
    ay   = (y < 0) ? -y : y;
    flip = (x < 0) != (y < 0);
    if (ax == 0 || ay == 0) return 0;
    if (ay > LIM_HI / ax) return flip ? LIM_LO : LIM_HI;
    return clip_acc(x * y);
  endfunction

  // Banerjee lower and upper bounds of one loop level, lower loop bound one.
  function automatic void level_bounds(input longint a, input longint b, input longint u,
                                       input logic [1:0] dir,
                                       output longint lo, output longint hi);
    longint um1;
    um1 = u - 1;
    case (dir)
      DIR_LESS: begin
        lo = -sat_product(plus_part(minus_part(a) + b), um1)
             + (minus_part(minus_part(a) + b) + plus_part(a)) - b;
        hi = sat_product(plus_part(plus_part(a) - b), um1)
             - (minus_part(plus_part(a) - b) + minus_part(a)) - b;
      end
      DIR_EQUAL: begin
        lo = -sat_product(minus_part(a - b), u) + plus_part(a - b);
        hi = sat_product(plus_part(a - b), u) - minus_part(a - b);
      end
      DIR_GREATER: begin
        lo = -sat_product(minus_part(a - plus_part(b)), um1)
             + plus_part(a - plus_part(b)) + minus_part(b) + a;
        hi = sat_product(plus_part(a - minus_part(b)), um1)
             + minus_part(a - minus_part(b)) + plus_part(b) + a;
      end
      default: begin
        lo = -sat_product(u, minus_part(a) + plus_part(b)) + (plus_part(a) + minus_part(b));
        hi = sat_product(u, plus_part(a) + minus_part(b)) - (minus_part(a) + plus_part(b));
      end
    endcase
  endfunction

  // Advances the predictor by one accepted request and queues the verdict it
  // causes, if any. A typed-in verdict from the directed table takes the place
  // of the computed one, while the state still moves on as usual.
  function automatic void apply_request(bdt_request_t r, logic typed, verdict_t typed_v);
    longint   lo;
    longint   hi;
    longint   gap;
    logic     closes_pair;
    verdict_t v;
    if (r.counts_differ) count_mismatch_seen = 1'b1;
    if (r.action == ACT_BEGIN) begin
      subscript_gap   = GAP_W'(longint'(r.second_offset) - longint'(r.first_offset));
      lower_bound_sum = '0;
      upper_bound_sum = '0;
      if (!decision_held && r.first_index_ref != r.second_index_ref) begin
        decision_held = 1'b1;
        held_cause    = RSN_MISMATCH;
      end
      return;
    end
    level_bounds(longint'(r.first_coeff), longint'(r.second_coeff), longint'(r.trip_count),
                 r.direction, lo, hi);
    lower_bound_sum = ACC_W'(clip_acc(longint'(lower_bound_sum) + clip_acc(lo)));
    upper_bound_sum = ACC_W'(clip_acc(longint'(upper_bound_sum) + clip_acc(hi)));
    closes_pair = r.last_term || r.last_subscript;
    gap = longint'(subscript_gap);
    if (closes_pair && !decision_held &&
        !(longint'(lower_bound_sum) <= gap && gap <= longint'(upper_bound_sum))) begin
      decision_held = 1'b1;
      held_cause    = RSN_VIOLATED;
    end
    if (!r.last_subscript) return;
    if (count_mismatch_seen) begin
      v = '{1'b1, RSN_COUNTS};
    end else if (decision_held && held_cause == RSN_VIOLATED) begin
      v = '{1'b0, RSN_VIOLATED};
    end else if (decision_held) begin
      v = '{1'b1, held_cause};
    end else begin
      v = '{1'b1, RSN_HELD};
    end
    expected_verdicts.insert(expected_verdicts.size(), typed ? typed_v : v);
    clear_predictor();
  endfunction

  // Idle length for either side: mostly none or short, now and then long,
  // and occasionally a run of requests with no idling at all.
  function automatic int pick_gap(inout int burst_left);
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic put_request(input bdt_request_t r);
    in_ch.action           <= r.action;
    in_ch.first_offset     <= r.first_offset;
    in_ch.second_offset    <= r.second_offset;
    in_ch.first_index_ref  <= r.first_index_ref;
    in_ch.second_index_ref <= r.second_index_ref;
    in_ch.counts_differ    <= r.counts_differ;
    in_ch.first_coeff      <= r.first_coeff;
    in_ch.second_coeff     <= r.second_coeff;
    in_ch.trip_count       <= r.trip_count;
    in_ch.direction        <= r.direction;
    in_ch.last_term        <= r.last_term;
    in_ch.last_subscript   <= r.last_subscript;
  endtask

  // Called and returning on a falling edge. Valid gets one assignment per
  // edge, so a request that follows straight on keeps valid high throughout.
  task automatic send_request(input bdt_request_t r, input logic typed, input verdict_t typed_v);
    int idle;
    idle = pick_gap(tx_burst);
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    put_request(r);
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    apply_request(r, typed, typed_v);
    requests_sent++;
    @(negedge clk);
  endtask

  // Every field random, including the ones the action leaves unused.
  function automatic bdt_request_t random_request();
    bdt_request_t r;
    r.action           = 1'($urandom);
    r.first_offset     = OFF_W'($urandom);
    r.second_offset    = OFF_W'($urandom);
    r.first_index_ref  = REF_W'($urandom);
    r.second_index_ref = REF_W'($urandom);
    r.counts_differ    = ($urandom_range(0, 9) == 0);
    r.first_coeff      = COEFF_W'($urandom);
    r.second_coeff     = COEFF_W'($urandom);
    r.trip_count       = COUNT_W'($urandom);
    r.direction        = 2'($urandom);
    r.last_term        = 1'($urandom);
    r.last_subscript   = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  // Small values keep the inequality near its edges, so both outcomes turn up.
  function automatic logic signed [COEFF_W-1:0] pick_coeff();
    int v;
    v = int'($urandom_range(0, 16)) - 8;
    if ($urandom_range(0, 4) == 0) return COEFF_W'($urandom);
    return COEFF_W'(v);
  endfunction

  function automatic logic signed [OFF_W-1:0] pick_offset();
    int v;
    v = int'($urandom_range(0, 60)) - 30;
    if ($urandom_range(0, 4) == 0) return OFF_W'($urandom);
    return OFF_W'(v);
  endfunction

  function automatic logic [COUNT_W-1:0] pick_trips();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll < 3) return COUNT_W'($urandom);
    return COUNT_W'($urandom_range(1, 12));
  endfunction

  // One well-formed test with random content: one to three subscript pairs of
  // one to four levels. Now and then a pair loses its begin request. The
  // saturating shapes run a single long pair at the coefficient extremes.
  task automatic run_test(input test_shape_t shape);
    bdt_request_t r;
    logic [REF_W-1:0] shared;
    int pairs;
    int levels;
    pairs = (shape == SHAPE_PLAIN) ? $urandom_range(1, 3) : 1;
    for (int p = 0; p < pairs; p++) begin
      if (shape != SHAPE_PLAIN || $urandom_range(0, 19) != 0) begin
        r = random_request();
        r.action        = ACT_BEGIN;
        r.first_offset  = pick_offset();
        r.second_offset = pick_offset();
        r.counts_differ = ($urandom_range(0, 29) == 0);
        shared = ($urandom_range(0, 3) == 0) ? REF_W'($urandom) : '0;
        r.first_index_ref  = shared;
        r.second_index_ref = shared;
        if ($urandom_range(0, 9) == 0) begin
          r.second_index_ref = shared ^ REF_W'($urandom_range(1, 65535));
        end
        send_request(r, 1'b0, '0);
      end
      levels = (shape == SHAPE_PLAIN) ? $urandom_range(1, 4) : SAT_LEVELS;
      for (int l = 0; l < levels; l++) begin
        r = random_request();
        r.action        = ACT_TERM;
        r.counts_differ = ($urandom_range(0, 49) == 0);
        if (shape == SHAPE_SAT_LOW) begin
          r.first_coeff  = COEFF_W'(16'h8000);
          r.second_coeff = COEFF_W'(16'h7fff);
          r.trip_count   = '1;
          r.direction    = DIR_ANY;
        end else if (shape == SHAPE_SAT_HIGH) begin
          r.first_coeff  = COEFF_W'(16'h7fff);
          r.second_coeff = COEFF_W'(16'h8000);
          r.trip_count   = '1;
          r.direction    = DIR_ANY;
        end else begin
          r.first_coeff  = pick_coeff();
          r.second_coeff = pick_coeff();
          r.trip_count   = pick_trips();
        end
        r.last_term      = 1'b0;
        r.last_subscript = 1'b0;
        if (l == levels - 1) begin
          if (p == pairs - 1) begin
            r.last_subscript = 1'b1;
            r.last_term      = 1'($urandom);
          end else begin
            r.last_term = 1'b1;
          end
        end
        send_request(r, 1'b0, '0);
      end
    end
  endtask

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%t: %s", $realtime, msg);
  endtask

  // Stimulus: reset, the directed table, then random tests until the budget
  // of requests is spent, then the drain and the verdict on the whole run.
  initial begin
    verdict_t   typed_v;
    int         test_no;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    put_request('0);
    clear_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_N; i++) begin
      typed_v.dependent = directed_rows[i].dependent;
      typed_v.reason    = directed_rows[i].reason;
      send_request(directed_rows[i].req, directed_rows[i].typed, typed_v);
    end

    // About one test in ten is a short burst of arbitrary requests instead;
    // the two saturating tests sit at fixed places in the sequence.
    test_no = 0;
    while (requests_sent < DIRECTED_N + RANDOM_ITEMS) begin
      if (test_no == 12) begin
        run_test(SHAPE_SAT_LOW);
      end else if (test_no == 40) begin
        run_test(SHAPE_SAT_HIGH);
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) send_request(random_request(), 1'b0, '0);
      end else begin
        run_test(SHAPE_PLAIN);
      end
      test_no++;
    end
    in_ch.valid <= 1'b0;

    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_verdicts.size() == 0) begin
      $display("** banerjee_dependence_test_top: PASSED **");
    end else begin
      $display("** banerjee_dependence_test_top: FAILED **");
    end
    $finish;
  end

  // Receiver. It idles at random like the sender, and twice it holds ready
  // low for a long stretch while a verdict waits, so that the block's queue
  // fills up and in_ch.ready has to fall.
  initial begin
    int rx_hold;
    int rx_burst;
    int holds_done;
    rx_hold    = 0;
    rx_burst   = 0;
    holds_done = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold == 0 && holds_done < 2 && out_ch.valid === 1'b1 &&
          verdicts_seen >= ((holds_done == 0) ? 3 : 30)) begin
        rx_hold = HOLD_CYCLES;
        holds_done++;
      end
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ch.ready <= 1'b1;
        rx_hold = pick_gap(rx_burst);
      end
    end
  end

  // Verdict checker: every verdict taken is compared with the oldest one
  // still expected.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        note_fault($sformatf("unexpected verdict: dependent=%0b reason=%0d",
                             out_ch.dependent, out_ch.reason));
      end else begin
        want = expected_verdicts.pop_front();
        if (out_ch.dependent !== want.dependent || out_ch.reason !== want.reason) begin
          note_fault($sformatf({"verdict %0d: expected dependent=%0b reason=%0d, ",
                                "got dependent=%0b reason=%0d"},
                               verdicts_seen, want.dependent, want.reason,
                               out_ch.dependent, out_ch.reason));
        end
      end
    end
  end

  // Watchdog, several times the slowest plausible run.
  initial begin
    #5_000_000;
    $display("** banerjee_dependence_test_top: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/bdt_pkg.sv
hdl/bdt_if.sv
hdl/bdt_front.sv
hdl/bdt_queue.sv
hdl/bdt_back.sv
hdl/banerjee_dependence_test_top.sv
bench/banerjee_dependence_test_top_tb.sv
